FILE: design/assert_macros.svh
// Shared assertion macros for the design folder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/raosc_pkg.sv
package raosc_pkg;

   localparam int FRAC_BITS_DEF = 24;
   localparam int WORD_W = 32;
   localparam int CSR_IDX_W = 3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_A = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_B = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_C = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_DT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_START_X = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_START_Y = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_START_Z = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERP_RATE = 3'd7;

   // Axis codes
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   // Datapath micro-operations
   typedef enum logic [4:0] {
      OP_IDLE,
      OP_PHASE,    // phase += rate
      OP_FX,       // fx = -(y+z)
      OP_MAY,      // prod = a*y
      OP_FY,       // fy = x + r(prod)
      OP_MXZ,      // prod = x*z
      OP_T1,       // t = r(prod)
      OP_MCZ,      // prod = c*z
      OP_FZ,       // fz = b + t - r(prod)
      OP_MDX,      // prod = dt*fx
      OP_PX,
      OP_MDY,
      OP_PY,
      OP_MDZ,
      OP_PZ,
      OP_GX,       // sum fx + gx
      OP_MPAY,
      OP_GY,
      OP_MPXZ,
      OP_PT1,
      OP_MPCZ,
      OP_GZ,
      OP_MHX,      // prod = dt*(fx+gx)
      OP_UX,
      OP_MHY,
      OP_UY,
      OP_MHZ,
      OP_UZ,
      OP_PICK,     // commit point, pick axis, ramp update
      OP_MRAMP,    // prod = phase*delta
      OP_OUT       // load output register
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_HOLD
   } state_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic stepping;   // interp off or phase reached one
      logic ramp;       // interp on
   } status_type;

endpackage

FILE: design/raosc_ctrl.sv
`include "assert_macros.svh"
module raosc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  raosc_pkg::status_type  status,
   output raosc_pkg::cmd_type     cmd
);
   raosc_pkg::state_type state_ff, state_in;
   raosc_pkg::op_type    op_ff, op_in;

   // Next state and next op
   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      unique case (state_ff)
         raosc_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = raosc_pkg::ST_RUN;
               op_in = raosc_pkg::OP_PHASE;
            end
         end
         raosc_pkg::ST_RUN: begin
            if (op_ff == raosc_pkg::OP_PHASE) begin
               op_in = status.stepping ? raosc_pkg::OP_FX : raosc_pkg::OP_MRAMP;
            end else if (op_ff == raosc_pkg::OP_PICK) begin
               op_in = status.ramp ? raosc_pkg::OP_MRAMP : raosc_pkg::OP_OUT;
            end else if (op_ff == raosc_pkg::OP_OUT) begin
               state_in = raosc_pkg::ST_HOLD;
               op_in = raosc_pkg::OP_IDLE;
            end else begin
               op_in = raosc_pkg::op_type'(op_ff + 5'd1);
            end
         end
         raosc_pkg::ST_HOLD: begin
            if (!rsp_stall) begin
               state_in = raosc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = raosc_pkg::ST_IDLE;
            op_in = raosc_pkg::OP_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      req_stall = (state_ff != raosc_pkg::ST_IDLE);
      rsp_valid = (state_ff == raosc_pkg::ST_HOLD);
      cmd.op = op_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= raosc_pkg::ST_IDLE;
         op_ff <= raosc_pkg::OP_IDLE;
      end else begin
         state_ff <= state_in;
         op_ff <= op_in;
      end
   end

   `ASSERT_IMPL(a_op_idle, clock, reset, state_ff != raosc_pkg::ST_RUN, op_ff == raosc_pkg::OP_IDLE, "op active outside run")
   `ASSERT_NEXT(a_hold_stays, clock, reset, rsp_valid && rsp_stall, rsp_valid, "result dropped under stall")
   `ASSERT_NEXT(a_out_hold, clock, reset, op_ff == raosc_pkg::OP_OUT, rsp_valid, "no result after out")
endmodule

FILE: design/raosc_dp.sv
`include "assert_macros.svh"
module raosc_dp #(
   parameter int FRAC_BITS = raosc_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic [raosc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [raosc_pkg::WORD_W-1:0]      csr_data,
   input  logic                              req_accept,
   input  logic [1:0]                        req_axis,
   input  raosc_pkg::cmd_type                cmd,
   output raosc_pkg::status_type             status,
   output logic signed [31:0]                rsp_sample
);
   localparam int DT_W = FRAC_BITS + 1;
   localparam int PH_W = FRAC_BITS + 2;
   localparam logic signed [63:0] ONE_Q = 64'sd1 <<< FRAC_BITS;
   localparam logic signed [63:0] MAXV = 64'sd2147483647;
   localparam logic signed [63:0] MINV = -64'sd2147483648;
   // Defaults: a = b = 0.2, c = 5.7, dt = 0.01, rounded to nearest
   localparam logic signed [31:0] AB_RST = 32'((64'sd2 * ONE_Q + 64'sd5) / 64'sd10);
   localparam logic signed [31:0] C_RST = 32'((64'sd57 * ONE_Q + 64'sd5) / 64'sd10);
   localparam logic [DT_W-1:0] DT_RST = DT_W'((ONE_Q + 64'sd50) / 64'sd100);

   // Configuration and state
   logic signed [31:0] a_ff, b_ff, c_ff;
   logic [DT_W-1:0] dt_ff, rate_ff;
   logic signed [31:0] x_ff, y_ff, z_ff;
   logic [PH_W-1:0] phase_ff, phase_in;
   logic signed [31:0] src_ff, tgt_ff;
   logic signed [32:0] dlt_ff;
   logic [1:0] axis_ff;
   logic signed [31:0] fx_ff, fy_ff, fz_ff, px_ff, py_ff, pz_ff, t_ff;
   logic signed [32:0] sum_x_ff, sum_y_ff, sum_z_ff;
   logic signed [31:0] nx_ff, ny_ff, nz_ff;
   logic signed [63:0] prod_ff;
   logic signed [31:0] out_ff;
   logic step_ff;

   function automatic logic signed [31:0] sat(input logic signed [63:0] v);
      if (v > MAXV) return 32'sh7fffffff;
      if (v < MINV) return 32'sh80000000;
      return v[31:0];
   endfunction

   // Round to nearest, ties up: floor((q + half) / 2^s) equals arithmetic shift
   function automatic logic signed [63:0] rsh(input logic signed [63:0] q,
                                              input int s);
      logic signed [63:0] t;
      t = q + (64'sd1 <<< (s - 1));
      return t >>> s;
   endfunction

   // Multiplier operands
   logic signed [32:0] m_a, m_b;
   always_comb begin
      m_a = '0;
      m_b = '0;
      unique case (cmd.op)
         raosc_pkg::OP_MAY:  begin m_a = 33'(a_ff); m_b = 33'(y_ff); end
         raosc_pkg::OP_MXZ:  begin m_a = 33'(x_ff); m_b = 33'(z_ff); end
         raosc_pkg::OP_MCZ:  begin m_a = 33'(c_ff); m_b = 33'(z_ff); end
         raosc_pkg::OP_MDX:  begin m_a = 33'(signed'({1'b0, dt_ff})); m_b = 33'(fx_ff); end
         raosc_pkg::OP_MDY:  begin m_a = 33'(signed'({1'b0, dt_ff})); m_b = 33'(fy_ff); end
         raosc_pkg::OP_MDZ:  begin m_a = 33'(signed'({1'b0, dt_ff})); m_b = 33'(fz_ff); end
         raosc_pkg::OP_MPAY: begin m_a = 33'(a_ff); m_b = 33'(py_ff); end
         raosc_pkg::OP_MPXZ: begin m_a = 33'(px_ff); m_b = 33'(pz_ff); end
         raosc_pkg::OP_MPCZ: begin m_a = 33'(c_ff); m_b = 33'(pz_ff); end
         raosc_pkg::OP_MHX:  begin m_a = 33'(signed'({1'b0, dt_ff})); m_b = sum_x_ff; end
         raosc_pkg::OP_MHY:  begin m_a = 33'(signed'({1'b0, dt_ff})); m_b = sum_y_ff; end
         raosc_pkg::OP_MHZ:  begin m_a = 33'(signed'({1'b0, dt_ff})); m_b = sum_z_ff; end
         raosc_pkg::OP_MRAMP: begin m_a = 33'(signed'({1'b0, phase_ff})); m_b = dlt_ff; end
         default: begin end
      endcase
   end

   logic signed [63:0] rp, rh;
   logic signed [31:0] mp;
   always_comb begin
      rp = rsh(prod_ff, FRAC_BITS);
      rh = rsh(prod_ff, FRAC_BITS + 1);
      mp = sat(rp);
   end

   logic [PH_W-1:0] rate_c;
   always_comb begin
      rate_c = (64'(rate_ff) > ONE_Q) ? PH_W'(ONE_Q) : PH_W'(rate_ff);
      phase_in = phase_ff + rate_c;
      status.ramp = (rate_ff != '0);
      status.stepping = (rate_ff == '0) || (64'(phase_in) >= ONE_Q);
   end

   logic signed [31:0] pick;
   always_comb begin
      unique case (axis_ff)
         raosc_pkg::AXIS_Y: pick = ny_ff;
         raosc_pkg::AXIS_Z: pick = nz_ff;
         default:           pick = nx_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= 64'(m_a) * 64'(m_b);
      if (req_accept) axis_ff <= req_axis;
      unique case (cmd.op)
         raosc_pkg::OP_FX:  fx_ff <= sat(-(64'(y_ff) + 64'(z_ff)));
         raosc_pkg::OP_FY:  fy_ff <= sat(64'(x_ff) + 64'(mp));
         raosc_pkg::OP_T1, raosc_pkg::OP_PT1: t_ff <= mp;
         raosc_pkg::OP_FZ:  fz_ff <= sat(64'(b_ff) + 64'(t_ff) - 64'(mp));
         raosc_pkg::OP_PX:  px_ff <= sat(64'(x_ff) + 64'(mp));
         raosc_pkg::OP_PY:  py_ff <= sat(64'(y_ff) + 64'(mp));
         raosc_pkg::OP_PZ:  pz_ff <= sat(64'(z_ff) + 64'(mp));
         raosc_pkg::OP_GX:  sum_x_ff <= 33'(fx_ff) + 33'(sat(-(64'(py_ff) + 64'(pz_ff))));
         raosc_pkg::OP_GY:  sum_y_ff <= 33'(fy_ff) + 33'(sat(64'(px_ff) + 64'(mp)));
         raosc_pkg::OP_GZ:  sum_z_ff <= 33'(fz_ff)
                               + 33'(sat(64'(b_ff) + 64'(t_ff) - 64'(mp)));
         raosc_pkg::OP_UX:  nx_ff <= sat(64'(x_ff) + rh);
         raosc_pkg::OP_UY:  ny_ff <= sat(64'(y_ff) + rh);
         raosc_pkg::OP_UZ:  nz_ff <= sat(64'(z_ff) + rh);
         default: begin end
      endcase
      // Output register
      if (cmd.op == raosc_pkg::OP_OUT) begin
         if (rate_ff == '0) begin
            unique case (axis_ff)
               raosc_pkg::AXIS_Y: out_ff <= y_ff;
               raosc_pkg::AXIS_Z: out_ff <= z_ff;
               default:           out_ff <= x_ff;
            endcase
         end else begin
            out_ff <= sat(64'(src_ff) + rp);
         end
      end
   end

   // Architectural state with reset values
   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff <= AB_RST;
         b_ff <= AB_RST;
         c_ff <= C_RST;
         dt_ff <= DT_RST;
         x_ff <= 32'(ONE_Q);
         y_ff <= 32'(ONE_Q);
         z_ff <= 32'(ONE_Q);
         rate_ff <= '0;
         phase_ff <= '0;
         src_ff <= '0;
         tgt_ff <= '0;
         dlt_ff <= '0;
         step_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               raosc_pkg::CSR_COEF_A: a_ff <= csr_data;
               raosc_pkg::CSR_COEF_B: b_ff <= csr_data;
               raosc_pkg::CSR_COEF_C: c_ff <= csr_data;
               raosc_pkg::CSR_STEP_DT: dt_ff <= csr_data[DT_W-1:0];
               raosc_pkg::CSR_START_X: x_ff <= csr_data;
               raosc_pkg::CSR_START_Y: y_ff <= csr_data;
               raosc_pkg::CSR_START_Z: z_ff <= csr_data;
               raosc_pkg::CSR_INTERP_RATE: rate_ff <= csr_data[DT_W-1:0];
               default: begin end
            endcase
         end
         if (cmd.op == raosc_pkg::OP_PHASE) begin
            step_ff <= status.stepping;
            if (status.ramp) begin
               phase_ff <= status.stepping ? phase_in - PH_W'(ONE_Q) : phase_in;
            end
         end
         if (cmd.op == raosc_pkg::OP_PICK) begin
            x_ff <= nx_ff;
            y_ff <= ny_ff;
            z_ff <= nz_ff;
            if (rate_ff != '0) begin
               src_ff <= tgt_ff;
               tgt_ff <= pick;
               dlt_ff <= 33'(pick) - 33'(tgt_ff);
            end
         end
      end
   end

   assign rsp_sample = out_ff;

   `ASSERT_IMPL(a_phase_lt_one, clock, reset, 1'b1, 64'(phase_ff) < ONE_Q, "phase reached one")
   `ASSERT_IMPL(a_pick_steps, clock, reset, cmd.op == raosc_pkg::OP_PICK, step_ff, "commit without step")
endmodule

FILE: design/rossler_attractor_oscillator_top.sv
// Rossler attractor oscillator, Heun integration in signed fixed point.
// Input channel req_*: one beat carries req_axis (0 x, 1 y, 2 z, 3 x).
// Result channel rsp_*: one beat per request carries rsp_sample, saturated.
// csr_*: plain write port, index per register list; write only while idle.
// A start register write also loads that point coordinate.
// A stepping request runs OP_PHASE, the Heun step through OP_PICK, then
// OP_MRAMP when the ramp is on, and OP_OUT; a ramp-only request (phase
// below one) runs OP_PHASE, OP_MRAMP and OP_OUT. One request at a time;
// the next accept comes only once the result beat is taken and the
// sequencer is back in idle, and an item's pace is set by the single shared
// 33x33 multiplier that the sequencer walks through the Heun step.
// Reset: coefficients and start point return to defaults, phase and ramp
// clear, no beat is pending.
// When the receiver stalls, rsp_sample holds and req_stall stays high until
// the result beat is taken.
module rossler_attractor_oscillator_top #(
   parameter int FRAC_BITS = raosc_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_axis,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [31:0]               rsp_sample,
   input  logic                             csr_write,
   input  logic [raosc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [raosc_pkg::WORD_W-1:0]     csr_data
);
   raosc_pkg::cmd_type    cmd;
   raosc_pkg::status_type status;

   raosc_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .status(status), .cmd(cmd)
   );

   raosc_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_accept(req_valid && !req_stall), .req_axis(req_axis),
      .cmd(cmd), .status(status), .rsp_sample(rsp_sample)
   );
endmodule
